[hw/rtl/lsps_pkg.sv]
package lsps_pkg;

  localparam int NSCENES   = 5;
  localparam int TICK_STEP = 10;
  localparam int TIME_UNIT = 1;

  typedef logic [2:0]  scene_id_t;
  typedef logic [1:0]  mode_t;
  typedef logic [1:0]  prio_t;
  typedef logic [4:0]  scene_vec_t;
  typedef logic [15:0] stime_t;
  typedef logic [7:0]  rep_t;
  typedef logic [23:0] rgb_t;

  localparam mode_t MODE_TICK   = 2'd0;
  localparam mode_t MODE_START  = 2'd1;
  localparam mode_t MODE_CANCEL = 2'd2;

  localparam scene_id_t SCENE_BOOT    = 3'd0;
  localparam scene_id_t SCENE_PAIRING = 3'd1;
  localparam scene_id_t SCENE_TRIGGER = 3'd2;
  localparam scene_id_t SCENE_ERROR   = 3'd3;
  localparam scene_id_t SCENE_SUCCESS = 3'd4;
  localparam scene_id_t SCENE_NONE    = 3'd5;

  localparam logic [2:0] CFG_IDX_BOOTUP  = 3'd0;
  localparam logic [2:0] CFG_IDX_PAIRING = 3'd1;
  localparam logic [2:0] CFG_IDX_TRIGGER = 3'd2;
  localparam logic [2:0] CFG_IDX_ERROR   = 3'd3;
  localparam logic [2:0] CFG_IDX_SUCCESS = 3'd4;

  localparam stime_t DUR_2000 = stime_t'(2000 * TIME_UNIT);
  localparam stime_t DUR_1000 = stime_t'(1000 * TIME_UNIT);
  localparam stime_t DUR_500  = stime_t'(500 * TIME_UNIT);
  localparam stime_t DUR_100  = stime_t'(100 * TIME_UNIT);
  localparam logic [16:0] TICK_INC = 17'(TICK_STEP);

  localparam rgb_t RGB_BLACK = 24'h000000;
  localparam rgb_t RGB_RED   = 24'hFF0000;
  localparam rgb_t RGB_BLUE  = 24'h0000FF;

  localparam prio_t PRIO_RST_BOOTUP  = 2'd2;
  localparam prio_t PRIO_RST_PAIRING = 2'd0;
  localparam prio_t PRIO_RST_TRIGGER = 2'd1;
  localparam prio_t PRIO_RST_ERROR   = 2'd1;
  localparam prio_t PRIO_RST_SUCCESS = 2'd1;

  function automatic rgb_t step_color(scene_id_t s, logic k);
    rgb_t c;
    c = RGB_BLACK;
    case (s)
      SCENE_BOOT:    c = RGB_RED;
      SCENE_PAIRING: c = k ? RGB_BLACK : RGB_BLUE;
      SCENE_TRIGGER: c = k ? RGB_RED : RGB_BLACK;
      SCENE_ERROR:   c = k ? RGB_BLACK : RGB_RED;
      SCENE_SUCCESS: c = k ? RGB_RED : RGB_BLUE;
      default:       c = RGB_BLACK;
    endcase
    return c;
  endfunction

  function automatic stime_t step_dur(scene_id_t s);
    stime_t d;
    d = DUR_100;
    case (s)
      SCENE_BOOT:    d = DUR_2000;
      SCENE_PAIRING: d = DUR_1000;
      SCENE_TRIGGER: d = DUR_500;
      SCENE_ERROR:   d = DUR_100;
      SCENE_SUCCESS: d = DUR_500;
      default:       d = DUR_100;
    endcase
    return d;
  endfunction

  function automatic logic scene_last_step(scene_id_t s, logic k);
    return (s == SCENE_BOOT) ? 1'b1 : k;
  endfunction

  function automatic rep_t scene_repeats(scene_id_t s);
    rep_t r;
    r = 8'd1;
    case (s)
      SCENE_BOOT:    r = 8'd1;
      SCENE_PAIRING: r = 8'd30;
      SCENE_TRIGGER: r = 8'd10;
      SCENE_ERROR:   r = 8'd10;
      SCENE_SUCCESS: r = 8'd20;
      default:       r = 8'd1;
    endcase
    return r;
  endfunction

  function automatic scene_vec_t scene_bit(scene_id_t s);
    scene_vec_t v;
    v = '0;
    if (s < scene_id_t'(NSCENES)) begin
      v[s] = 1'b1;
    end
    return v;
  endfunction

endpackage

[hw/rtl/led_scene_priority_sequencer.sv]
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_mode, in_scene_id
// out_      output     out_valid / out_ready   out_red, out_green, out_blue, out_scene
// cfg_      input      cfg_we                  cfg_index, cfg_wdata
//
// One transaction per cycle unless the result register stalls: an accepted item sits
// in the input register, then scene state and result register update as it moves on.
// out_valid rises as a result moves from the input register to the result register.
// rst_n (synchronous) clears all scene state and both stages, resets the priorities.
// A stalled result register holds the input stage; in_ready drops only then.
module led_scene_priority_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [2:0] in_scene_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [2:0] out_scene,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [1:0] cfg_wdata
);

  localparam int N = lsps_pkg::NSCENES;

  lsps_pkg::prio_t      prio_r [N];
  logic                 s1_valid_r;
  lsps_pkg::mode_t      mode_r;
  lsps_pkg::scene_id_t  id_r;

  lsps_pkg::scene_vec_t running_r, running_nxt;
  lsps_pkg::scene_id_t  active_r, active_nxt;
  lsps_pkg::rep_t       rep_r [N];
  lsps_pkg::rep_t       rep_nxt [N];
  logic                 sidx_r [N];
  logic                 sidx_nxt [N];
  lsps_pkg::stime_t     stime_r [N];
  lsps_pkg::stime_t     stime_nxt [N];

  logic                 out_valid_r;
  lsps_pkg::rgb_t       rgb_r;
  lsps_pkg::scene_id_t  act_out_r;

  lsps_pkg::scene_vec_t pick_vec;
  lsps_pkg::scene_id_t  win_id;
  logic                 adv, fire;
  logic                 res_valid;
  lsps_pkg::rgb_t       res_rgb;

  logic                 act_live;
  logic                 id_ok;
  logic                 k_cur;
  logic [16:0]          t_sum;
  lsps_pkg::stime_t     t_sat;
  lsps_pkg::rep_t       rep_inc;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  assign act_live = (active_r < lsps_pkg::scene_id_t'(N)) && running_r[active_r];
  assign id_ok    = id_r < lsps_pkg::scene_id_t'(N);

  always_comb begin
    case (mode_r)
      lsps_pkg::MODE_START:  pick_vec = running_r | lsps_pkg::scene_bit(id_r);
      lsps_pkg::MODE_CANCEL: pick_vec = running_r & ~lsps_pkg::scene_bit(id_r);
      default:               pick_vec = running_r & ~lsps_pkg::scene_bit(active_r);
    endcase
  end

  lsps_winner u_winner (
    .run_vec (pick_vec),
    .prio    (prio_r),
    .win_id  (win_id)
  );

  always_comb begin
    running_nxt = running_r;
    active_nxt  = active_r;
    rep_nxt     = rep_r;
    sidx_nxt    = sidx_r;
    stime_nxt   = stime_r;
    res_valid   = 1'b0;
    res_rgb     = lsps_pkg::RGB_BLACK;
    k_cur       = 1'b0;
    t_sum       = '0;
    t_sat       = '0;
    rep_inc     = '0;
    case (mode_r)
      lsps_pkg::MODE_TICK: begin
        if (act_live) begin
          k_cur = sidx_r[active_r];
          t_sum = {1'b0, stime_r[active_r]} + lsps_pkg::TICK_INC;
          t_sat = t_sum[16] ? 16'hFFFF : t_sum[15:0];
          stime_nxt[active_r] = t_sat;
          if (t_sat < lsps_pkg::step_dur(active_r)) begin
            res_valid = 1'b1;
            res_rgb   = lsps_pkg::step_color(active_r, k_cur);
          end else if (!lsps_pkg::scene_last_step(active_r, k_cur)) begin
            sidx_nxt[active_r]  = 1'b1;
            stime_nxt[active_r] = '0;
          end else begin
            rep_inc = rep_r[active_r] + 8'd1;
            rep_nxt[active_r]  = rep_inc;
            sidx_nxt[active_r] = 1'b0;
            if (rep_inc >= lsps_pkg::scene_repeats(active_r)) begin
              running_nxt = pick_vec;
              active_nxt  = win_id;
              if (win_id < lsps_pkg::scene_id_t'(N)) begin
                stime_nxt[win_id] = '0;
              end
              res_valid = 1'b1;
            end else begin
              stime_nxt[active_r] = '0;
            end
          end
        end
      end
      lsps_pkg::MODE_START: begin
        if (id_ok && !running_r[id_r]) begin
          running_nxt = pick_vec;
          if (win_id != active_r) begin
            if (active_r < lsps_pkg::scene_id_t'(N)) begin
              running_nxt[active_r] = 1'b0;
            end
            active_nxt = win_id;
          end
          rep_nxt[id_r]   = '0;
          sidx_nxt[id_r]  = 1'b0;
          stime_nxt[id_r] = '0;
          if (active_nxt < lsps_pkg::scene_id_t'(N)) begin
            rep_nxt[active_nxt]   = '0;
            sidx_nxt[active_nxt]  = 1'b0;
            stime_nxt[active_nxt] = '0;
          end
        end
      end
      lsps_pkg::MODE_CANCEL: begin
        if (id_ok) begin
          running_nxt = pick_vec;
          if (active_r == id_r) begin
            active_nxt = win_id;
            if (win_id < lsps_pkg::scene_id_t'(N)) begin
              rep_nxt[win_id]   = '0;
              sidx_nxt[win_id]  = 1'b0;
              stime_nxt[win_id] = '0;
            end
            res_valid = 1'b1;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r[0] <= lsps_pkg::PRIO_RST_BOOTUP;
      prio_r[1] <= lsps_pkg::PRIO_RST_PAIRING;
      prio_r[2] <= lsps_pkg::PRIO_RST_TRIGGER;
      prio_r[3] <= lsps_pkg::PRIO_RST_ERROR;
      prio_r[4] <= lsps_pkg::PRIO_RST_SUCCESS;
    end else if (cfg_we) begin
      case (cfg_index)
        lsps_pkg::CFG_IDX_BOOTUP:  prio_r[0] <= cfg_wdata;
        lsps_pkg::CFG_IDX_PAIRING: prio_r[1] <= cfg_wdata;
        lsps_pkg::CFG_IDX_TRIGGER: prio_r[2] <= cfg_wdata;
        lsps_pkg::CFG_IDX_ERROR:   prio_r[3] <= cfg_wdata;
        lsps_pkg::CFG_IDX_SUCCESS: prio_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      id_r   <= in_scene_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      active_r  <= lsps_pkg::SCENE_NONE;
      for (int i = 0; i < N; i++) begin
        rep_r[i]   <= '0;
        sidx_r[i]  <= 1'b0;
        stime_r[i] <= '0;
      end
    end else if (fire) begin
      running_r <= running_nxt;
      active_r  <= active_nxt;
      rep_r     <= rep_nxt;
      sidx_r    <= sidx_nxt;
      stime_r   <= stime_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      rgb_r     <= res_rgb;
      act_out_r <= active_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = rgb_r[23:16];
  assign out_green = rgb_r[15:8];
  assign out_blue  = rgb_r[7:0];
  assign out_scene = act_out_r;

  a_active_running: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == lsps_pkg::SCENE_NONE) || act_live)
    else $error("active scene is not running");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= lsps_pkg::SCENE_NONE)
    else $error("active scene id out of range");

  a_none_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (act_out_r == lsps_pkg::SCENE_NONE)) |-> (rgb_r == lsps_pkg::RGB_BLACK))
    else $error("non-black result with no active scene");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> ($stable(running_r) && $stable(active_r)))
    else $error("scene state changed during output stall");

endmodule

[hw/rtl/lsps_winner.sv]
module lsps_winner (
  input  lsps_pkg::scene_vec_t run_vec,
  input  lsps_pkg::prio_t      prio [lsps_pkg::NSCENES],
  output lsps_pkg::scene_id_t  win_id
);

  logic [2:0]          best_prio;
  lsps_pkg::scene_id_t best_id;

  always_comb begin
    best_prio = 3'd4;
    best_id   = lsps_pkg::SCENE_NONE;
    for (int i = 0; i < lsps_pkg::NSCENES; i++) begin
      if (run_vec[i] && ({1'b0, prio[i]} < best_prio)) begin
        best_prio = {1'b0, prio[i]};
        best_id   = lsps_pkg::scene_id_t'(i);
      end
    end
  end

  assign win_id = best_id;

endmodule
